FILE: rtl/core/dhfk_pkg.sv
// ----------------------------------------------------------------------------
// dhfk_pkg: shared constants for the DH forward kinematics chain unit
// Fixed-point constants and the sine micro-step tables used by the sequencer.
// ----------------------------------------------------------------------------
package dhfk_pkg;

  localparam int unsigned InWidth   = 72;
  localparam int unsigned OutWidth  = 136;

  localparam logic signed [17:0] OneQ16   = 18'sd65536;
  localparam logic [30:0]        OneQ30   = 31'h4000_0000;
  localparam logic [32:0]        RadStep  = 33'd102944;
  localparam logic signed [23:0] OrgMax   = 24'sh7F_FFFF;
  localparam logic signed [23:0] OrgMin   = -24'sh80_0000;
  localparam logic signed [17:0] RotMax   = 18'sh1_FFFF;
  localparam logic signed [17:0] RotMin   = -18'sh2_0000;

  // Sine micro-steps, one multiplier operation each.
  localparam logic [3:0] SStepT   = 4'd0;   // t = r * radians-per-step
  localparam logic [3:0] SStepU   = 4'd1;   // u = t * t
  localparam logic [3:0] SStepFin = 4'd13;  // s = t * p

  // Divisor of the Horner stage that a reciprocal or check step belongs to.
  function automatic logic [7:0] div_of(input logic [3:0] step);
    logic [7:0] d;
    case (step)
      4'd2, 4'd3:  d = 8'd72;
      4'd5, 4'd6:  d = 8'd42;
      4'd8, 4'd9:  d = 8'd20;
      default:     d = 8'd6;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), used for the reciprocal multiply.
  function automatic logic [31:0] recip_of(input logic [3:0] step);
    logic [31:0] m;
    case (step)
      4'd2:    m = 32'd59652323;
      4'd5:    m = 32'd102261126;
      4'd8:    m = 32'd214748364;
      default: m = 32'd715827882;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/core/dh_forward_kinematics_chain_unit.sv
// ----------------------------------------------------------------------------
// dh_forward_kinematics_chain_unit: Denavit-Hartenberg chain accumulator
// A new joint is taken only once the result of the last one has been loaded;
// all 98 products of an item (four sines, six link terms, 36 matrix terms)
// go one by one through a single 33x33 multiplier, each in a multiply phase
// and then a write-back phase.
// Reset: asynchronous, active low; rotation returns to identity, origin and
// joint counter to zero, both channels idle.
// ----------------------------------------------------------------------------
module dh_forward_kinematics_chain_unit
  import dhfk_pkg::*;
#(
  parameter int unsigned MAX_JOINTS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // joint_angle[15:0], link_twist[31:16], link_length[49:32],
  // link_offset[67:50], zero fill [71:68]
  input  logic [InWidth-1:0]   s_axis_tdata_i,
  input  logic                 s_axis_tlast_i,   // chain_end
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // origin_x[23:0], origin_y[47:24], origin_z[71:48], axis_x[89:72],
  // axis_y[107:90], axis_z[125:108], joint_number[129:126], zero fill
  output logic [OutWidth-1:0]  m_axis_tdata_o,
  output logic                 m_axis_tuser_o    // saturated
);

  localparam logic [4:0] MaxJ = 5'(MAX_JOINTS);

  typedef enum logic [2:0] {StIdle, StSine, StLink, StMac, StDone} state_e;

  state_e state_q;
  logic   ph_q;           // 0: multiply, 1: write back

  // Item operands.
  logic [15:0]        angle_q, twist_q;
  logic signed [17:0] len_q, off_q;
  logic               end_q;

  // Sine unit registers.
  logic [1:0]  sg_q;      // which sine: sin t, cos t, sin a, cos a
  logic [3:0]  ss_q;
  logic [30:0] t_q, p_q;
  logic [31:0] u_q, x_q, q0_q;
  logic signed [17:0] sc_q [4];

  // Link terms and matrix sequencing.
  logic [2:0]  ls_q;
  logic signed [19:0] lk_q [6];
  logic [1:0]  i_q, c_q, k_q;
  logic signed [41:0] acc_q;
  logic signed [17:0] nrow_q [3];

  // Accumulated state.
  logic signed [17:0] rot_q [3][3];
  logic signed [23:0] org_q [3];
  logic [3:0]         cnt_q;

  // Result holding.
  logic signed [23:0] res_org_q [3];
  logic signed [17:0] res_axis_q [3];
  logic               sat_q;
  logic               m_valid_q;
  logic [OutWidth-1:0] m_data_q;
  logic               m_user_q;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q;

  // The angle whose sine is under way, folded into the first quadrant.
  logic [15:0] ang_c;
  logic [14:0] r_c;
  logic        neg_c;

  always_comb begin
    ang_c = (sg_q[1] ? twist_q : angle_q) + (sg_q[0] ? 16'h4000 : 16'h0000);
    r_c   = ang_c[14] ? (15'd16384 - {1'b0, ang_c[13:0]}) : {1'b0, ang_c[13:0]};
    neg_c = ang_c[15];
  end

  // Link matrix entry at row k, column c; column 3 is the link offset vector.
  logic signed [19:0] lval_c;
  always_comb begin
    case ({k_q, c_q})
      4'b00_00: lval_c = 20'(sc_q[1]);
      4'b00_01: lval_c = lk_q[0];
      4'b00_10: lval_c = lk_q[1];
      4'b00_11: lval_c = lk_q[4];
      4'b01_00: lval_c = 20'(sc_q[0]);
      4'b01_01: lval_c = lk_q[2];
      4'b01_10: lval_c = lk_q[3];
      4'b01_11: lval_c = lk_q[5];
      4'b10_01: lval_c = 20'(sc_q[2]);
      4'b10_10: lval_c = 20'(sc_q[3]);
      4'b10_11: lval_c = 20'(off_q);
      default:  lval_c = '0;
    endcase
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StSine: begin
        case (ss_q) inside
          SStepT: begin
            mul_a = 33'({18'b0, r_c});
            mul_b = RadStep;
          end
          SStepU: begin
            mul_a = 33'({2'b0, t_q});
            mul_b = 33'({2'b0, t_q});
          end
          4'd2, 4'd5, 4'd8, 4'd11: begin
            mul_a = 33'({1'b0, x_q});
            mul_b = 33'({1'b0, recip_of(ss_q)});
          end
          4'd3, 4'd6, 4'd9, 4'd12: begin
            mul_a = 33'({1'b0, q0_q});
            mul_b = 33'({25'b0, div_of(ss_q)});
          end
          4'd4, 4'd7, 4'd10: begin
            mul_a = 33'({1'b0, u_q});
            mul_b = 33'({2'b0, p_q});
          end
          default: begin
            mul_a = 33'({2'b0, t_q});
            mul_b = 33'({2'b0, p_q});
          end
        endcase
      end
      StLink: begin
        case (ls_q)
          3'd0:    begin mul_a = 33'(sc_q[3]); mul_b = 33'(sc_q[0]); end
          3'd1:    begin mul_a = 33'(sc_q[2]); mul_b = 33'(sc_q[0]); end
          3'd2:    begin mul_a = 33'(sc_q[3]); mul_b = 33'(sc_q[1]); end
          3'd3:    begin mul_a = 33'(sc_q[2]); mul_b = 33'(sc_q[1]); end
          3'd4:    begin mul_a = 33'(sc_q[1]); mul_b = 33'(len_q); end
          default: begin mul_a = 33'(sc_q[0]); mul_b = 33'(len_q); end
        endcase
      end
      StMac: begin
        mul_a = 33'(rot_q[i_q][k_q]);
        mul_b = 33'(lval_c);
      end
      default: ;
    endcase
  end

  // Write-back arithmetic.
  logic [33:0]        rem_c;
  logic [31:0]        qdiv_c;
  logic [32:0]        sr_c;
  logic [17:0]        qs_c;
  logic signed [35:0] lr_c;
  logic signed [41:0] sum_c, sumr_c;
  logic signed [25:0] rnd_c;
  logic signed [17:0] rclip_c;
  logic signed [26:0] no_c;
  logic signed [23:0] oclip_c;
  logic               ohit_c;

  always_comb begin
    rem_c  = {2'b0, x_q} - prod_q[33:0];
    qdiv_c = q0_q + ((rem_c >= 34'(div_of(ss_q))) ? 32'd1 : 32'd0);
    sr_c   = {1'b0, prod_q[61:30]} + 33'd8192;
    qs_c   = sr_c[31:14];
    if (qs_c > 18'd65536) qs_c = 18'd65536;
    lr_c   = prod_q[35:0] + 36'sd32768;
    sum_c  = acc_q + prod_q[41:0];
    sumr_c = sum_c + 42'sd32768;
    rnd_c  = sumr_c[41:16];
    if (rnd_c > 26'(RotMax))      rclip_c = RotMax;
    else if (rnd_c < 26'(RotMin)) rclip_c = RotMin;
    else                          rclip_c = rnd_c[17:0];
    no_c   = 27'(org_q[i_q]) + 27'(rnd_c);
    ohit_c = 1'b1;
    if (no_c > 27'(OrgMax))      oclip_c = OrgMax;
    else if (no_c < 27'(OrgMin)) oclip_c = OrgMin;
    else begin
      oclip_c = no_c[23:0];
      ohit_c  = 1'b0;
    end
  end

  logic out_free;
  assign out_free = !m_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      ph_q      <= 1'b0;
      m_valid_q <= 1'b0;
      cnt_q     <= '0;
      for (int r = 0; r < 3; r++) begin
        org_q[r] <= '0;
        for (int j = 0; j < 3; j++) rot_q[r][j] <= (r == j) ? OneQ16 : '0;
      end
    end else begin
      // The completion state loads the next result itself.
      if (m_valid_q && m_axis_tready_i && state_q != StDone) m_valid_q <= 1'b0;
      if (state_q != StIdle && state_q != StDone) begin
        ph_q <= !ph_q;
        if (!ph_q) prod_q <= mul_a * mul_b;
      end
      unique case (state_q)
        StIdle: begin
          if (s_axis_tvalid_i) begin
            angle_q <= s_axis_tdata_i[15:0];
            twist_q <= s_axis_tdata_i[31:16];
            len_q   <= s_axis_tdata_i[49:32];
            off_q   <= s_axis_tdata_i[67:50];
            end_q   <= s_axis_tlast_i || (({1'b0, cnt_q} + 5'd1) >= MaxJ);
            sat_q   <= 1'b0;
            sg_q    <= '0;
            ss_q    <= SStepT;
            ls_q    <= '0;
            i_q     <= '0;
            c_q     <= '0;
            k_q     <= '0;
            acc_q   <= '0;
            ph_q    <= 1'b0;
            state_q <= StSine;
          end
        end
        StSine: begin
          if (ph_q) begin
            if (ss_q != SStepFin) ss_q <= ss_q + 4'd1;
            case (ss_q) inside
              SStepT: t_q <= prod_q[30:0];
              SStepU: begin
                u_q <= prod_q[61:30];
                x_q <= prod_q[61:30];
              end
              4'd2, 4'd5, 4'd8, 4'd11: q0_q <= prod_q[63:32];
              4'd3, 4'd6, 4'd9, 4'd12: p_q <= OneQ30 - qdiv_c[30:0];
              4'd4, 4'd7, 4'd10:       x_q <= prod_q[61:30];
              default: begin
                sc_q[sg_q] <= neg_c ? -$signed(qs_c) : $signed(qs_c);
                ss_q       <= SStepT;
                sg_q       <= sg_q + 2'd1;
                if (sg_q == 2'd3) state_q <= StLink;
              end
            endcase
          end
        end
        StLink: begin
          if (ph_q) begin
            ls_q <= ls_q + 3'd1;
            if (ls_q == 3'd0 || ls_q == 3'd3) lk_q[ls_q] <= -lr_c[35:16];
            else                              lk_q[ls_q] <= lr_c[35:16];
            if (ls_q == 3'd5) state_q <= StMac;
          end
        end
        StMac: begin
          if (ph_q) begin
            if (k_q != 2'd2) begin
              acc_q <= sum_c;
              k_q   <= k_q + 2'd1;
            end else begin
              acc_q <= '0;
              k_q   <= '0;
              c_q   <= c_q + 2'd1;
              if (c_q != 2'd3) begin
                nrow_q[c_q] <= rclip_c;
              end else begin
                // Row done: its new values no longer feed any other row.
                res_org_q[i_q]  <= oclip_c;
                res_axis_q[i_q] <= nrow_q[2];
                sat_q           <= sat_q | ohit_c;
                org_q[i_q]      <= end_q ? '0 : oclip_c;
                for (int j = 0; j < 3; j++) begin
                  rot_q[i_q][j] <= end_q ? ((2'(j) == i_q) ? OneQ16 : '0) : nrow_q[j];
                end
                i_q <= i_q + 2'd1;
                if (i_q == 2'd2) state_q <= StDone;
              end
            end
          end
        end
        StDone: begin
          if (out_free) begin
            m_data_q  <= {6'b0, cnt_q, res_axis_q[2], res_axis_q[1], res_axis_q[0],
                          res_org_q[2], res_org_q[1], res_org_q[0]};
            m_user_q  <= sat_q;
            m_valid_q <= 1'b1;
            cnt_q     <= end_q ? '0 : cnt_q + 4'd1;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // The block works on one joint at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input taken while a joint is in progress");

  // A result only appears from the completion state.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == StDone))
    else $error("result raised outside completion");

  // The joint counter never reaches the chain length limit.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} < MaxJ)
    else $error("joint counter out of range");

  // Ending a chain leaves the accumulator at identity and zero origin.
  a_chain_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && out_free && end_q) |=>
      (rot_q[0][0] == OneQ16 && rot_q[1][1] == OneQ16 && rot_q[2][2] == OneQ16 &&
       rot_q[0][2] == '0 && org_q[0] == '0 && org_q[2] == '0 && cnt_q == '0))
    else $error("accumulator not restored after chain end");

endmodule

FILE: test/tb_dh_forward_kinematics_chain_unit.sv
// ----------------------------------------------------------------------------
// tb_dh_forward_kinematics_chain_unit: self-checking bench for the DH chain
// The bench drives a short table of joints and then random chains of random
// length. Each output transfer is checked field by field against a typed frame
// or a predictor that keeps its own rotation, origin and joint count. Both
// stream sides idle at random, and the receiver holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_dh_forward_kinematics_chain_unit;
  import dhfk_pkg::*;

  localparam int unsigned MaxJoints   = 8;
  localparam int unsigned RandomItems = 1080;
  localparam int unsigned QuietItems  = 150;   // no idling in the last part
  localparam int unsigned WatchLimit  = 6000;
  localparam int unsigned HoldCycles  = 900;

  // One expected output transfer.
  typedef struct {
    logic signed [23:0] org_x, org_y, org_z;
    logic signed [17:0] ax_x, ax_y, ax_z;
    logic [3:0]         joint;
    logic               sat;
  } frame_t;

  // One row of the directed table; frames are typed in only where obvious.
  typedef struct {
    logic signed [15:0] theta, alpha;
    logic signed [17:0] len, off;
    logic               last;
    logic               known;
    frame_t             frame;
  } joint_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [InWidth-1:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tready = 1'b0;
  logic s_tready, m_tvalid, m_tuser;
  logic [OutWidth-1:0] m_tdata;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  dh_forward_kinematics_chain_unit #(.MAX_JOINTS(MaxJoints)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  // Predictor state: running rotation (Q1.16), origin and joint position.
  longint rot_acc [3][3];
  longint org_acc [3];
  int unsigned joint_pos;

  frame_t frames_due[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  bit quiet = 1'b0;     // set for the tail of the run: no idling at all
  bit hold_req = 1'b0;  // asks the receiver for its long hold-off

  function automatic longint round_q16(longint v);
    return (v + 32768) >>> 16;
  endfunction

  // Taylor sine of a quarter-turn fraction r/16384, Q30 Horner, Q1.16 out.
  function automatic longint quarter_sin(longint unsigned r);
    longint unsigned t, u, p, s, q;
    t = r * 64'd102944;
    u = (t * t) >> 30;
    p = 64'd1073741824 - u / 72;
    p = 64'd1073741824 - ((u * p) >> 30) / 42;
    p = 64'd1073741824 - ((u * p) >> 30) / 20;
    p = 64'd1073741824 - ((u * p) >> 30) / 6;
    s = (t * p) >> 30;
    q = (s + 8192) >> 14;
    if (q > 65536) q = 65536;
    return longint'(q);
  endfunction

  function automatic longint bam_sin(logic [15:0] ang);
    logic [13:0] rem;
    longint unsigned r;
    longint s;
    rem = ang[13:0];
    r = ang[14] ? 16384 - rem : rem;
    s = quarter_sin(r);
    return ang[15] ? -s : s;
  endfunction

  function automatic longint bam_cos(logic [15:0] ang);
    return bam_sin(ang + 16'd16384);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi, ref bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void reset_chain();
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) rot_acc[i][j] = (i == j) ? 65536 : 0;
      org_acc[i] = 0;
    end
    joint_pos = 0;
  endfunction

  // Appends the link transform of one joint and returns the new frame.
  function automatic frame_t chain_joint(logic [15:0] theta, logic [15:0] alpha,
                                         logic signed [17:0] len,
                                         logic signed [17:0] off, logic last);
    longint ct, st, ca, sa, acc;
    longint link [3][3];
    longint lp [3];
    longint nrot [3][3];
    longint norg [3];
    bit sat, dummy;
    frame_t f;
    ct = bam_cos(theta);
    st = bam_sin(theta);
    ca = bam_cos(alpha);
    sa = bam_sin(alpha);
    sat = 1'b0;
    link[0][0] = ct;  link[0][1] = -round_q16(ca * st); link[0][2] = round_q16(sa * st);
    link[1][0] = st;  link[1][1] = round_q16(ca * ct);  link[1][2] = -round_q16(sa * ct);
    link[2][0] = 0;   link[2][1] = sa;                  link[2][2] = ca;
    lp[0] = round_q16(ct * longint'(len));
    lp[1] = round_q16(st * longint'(len));
    lp[2] = longint'(off);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int k = 0; k < 3; k++) acc += rot_acc[i][k] * lp[k];
      norg[i] = clamp(org_acc[i] + round_q16(acc), -8388608, 8388607, sat);
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot_acc[i][k] * link[k][j];
        nrot[i][j] = clamp(round_q16(acc), -131072, 131071, dummy);
      end
    end
    f.org_x = 24'(norg[0]); f.org_y = 24'(norg[1]); f.org_z = 24'(norg[2]);
    f.ax_x = 18'(nrot[0][2]); f.ax_y = 18'(nrot[1][2]); f.ax_z = 18'(nrot[2][2]);
    f.joint = joint_pos[3:0];
    f.sat = sat;
    // A flagged last joint, or the deepest allowed one, closes the chain.
    if (last || joint_pos + 1 >= MaxJoints) begin
      reset_chain();
    end else begin
      rot_acc = nrot;
      org_acc = norg;
      joint_pos = joint_pos + 1;
    end
    return f;
  endfunction

  // Offers one joint until it is transferred, then optionally idles.
  // A typed frame, where given, is what the output must carry.
  task automatic send_joint(logic [15:0] theta, logic [15:0] alpha,
                            logic [17:0] len, logic [17:0] off, logic last,
                            bit known, frame_t typed);
    frame_t f;
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, off, len, alpha, theta};
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_tready);
    f = chain_joint(theta, alpha, len, off, last);
    frames_due.push_back(known ? typed : f);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 3);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Receiver: random short stalls, one long hold-off, checks every transfer.
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    frame_t got, want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.org_x = m_tdata[23:0];    got.org_y = m_tdata[47:24];
        got.org_z = m_tdata[71:48];   got.ax_x  = m_tdata[89:72];
        got.ax_y  = m_tdata[107:90];  got.ax_z  = m_tdata[125:108];
        got.joint = m_tdata[129:126]; got.sat   = m_tuser;
        if (frames_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("output transfer with no frame pending");
        end else begin
          want = frames_due.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("frame mismatch: exp org %0d %0d %0d axis %0d %0d %0d j%0d s%0b",
                       want.org_x, want.org_y, want.org_z, want.ax_x, want.ax_y,
                       want.ax_z, want.joint, want.sat,
                       "\n                got org %0d %0d %0d axis %0d %0d %0d j%0d s%0b",
                       got.org_x, got.org_y, got.org_z, got.ax_x, got.ax_y,
                       got.ax_z, got.joint, got.sat);
          end
        end
      end
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req = 1'b0;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles without any transfer on either side.
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchLimit) begin
      $display("dh_forward_kinematics_chain_unit regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  joint_row_t rows [$];

  function automatic joint_row_t mk_row(int theta, int alpha, int len, int off,
                                        bit last);
    joint_row_t r;
    r.theta = 16'(theta); r.alpha = 16'(alpha);
    r.len = 18'(len); r.off = 18'(off); r.last = last;
    r.known = 1'b0;
    r.frame = '{default: '0};
    return r;
  endfunction

  initial begin
    joint_row_t r;
    int unsigned chain_len;
    frame_t none;
    none = '{default: '0};
    reset_chain();

    // Zero link after reset: origin stays at zero, z axis is straight up.
    r = mk_row(0, 0, 0, 0, 1'b1);
    r.known = 1'b1;
    r.frame.ax_z = 18'sd65536;
    rows.push_back(r);
    // Longest positive length, most negative offset, still no rotation.
    r = mk_row(0, 0, 131071, -131072, 1'b1);
    r.known = 1'b1;
    r.frame.org_x = 24'sd131071; r.frame.org_z = -24'sd131072;
    r.frame.ax_z = 18'sd65536;
    rows.push_back(r);
    // Angle and twist extremes with full-scale lengths, then quarter turns.
    rows.push_back(mk_row(-32768, 32767, -131072, 131071, 1'b0));
    rows.push_back(mk_row(32767, -32768, 131071, 131071, 1'b0));
    rows.push_back(mk_row(16384, -16384, 81920, -40000, 1'b0));
    rows.push_back(mk_row(-16384, 16384, -65536, 12345, 1'b1));
    // Nine joints without an end mark: the eighth closes the chain by itself.
    for (int i = 0; i < 9; i++)
      rows.push_back(mk_row(4096 * i - 16000, 8191 - 3000 * i, 1352 + 5000 * i,
                            5455 - 2000 * i, 1'b0));
    rows.push_back(mk_row(1, -1, -1, 1, 1'b1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i])
      send_joint(rows[i].theta, rows[i].alpha, rows[i].len, rows[i].off,
                 rows[i].last, rows[i].known, rows[i].known ? rows[i].frame : none);

    // Random chains, sometimes longer than the block allows.
    for (int n = 0; n < RandomItems; ) begin
      chain_len = $urandom_range(1, MaxJoints + 2);
      for (int k = 0; k < chain_len && n < RandomItems; k++, n++) begin
        if (n == 300) hold_req = 1'b1;
        if (n == RandomItems - QuietItems) quiet = 1'b1;
        send_joint(16'($urandom), 16'($urandom), 18'($urandom), 18'($urandom),
                   (k == chain_len - 1) ? 1'b1 : ($urandom_range(0, 15) == 0),
                   1'b0, none);
      end
    end
    s_tvalid <= 1'b0;
    s_tlast  <= 1'b0;

    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (250) @(posedge clk_i);
    if (mismatches == 0 && frames_due.size() == 0) begin
      $display("dh_forward_kinematics_chain_unit regression: pass");
    end else begin
      $display("dh_forward_kinematics_chain_unit regression: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/dhfk_pkg.sv
rtl/core/dh_forward_kinematics_chain_unit.sv
test/tb_dh_forward_kinematics_chain_unit.sv
